// ===== rtl/core/list_freshness_reuse_tracker_macros.svh =====
`ifndef LIST_FRESHNESS_REUSE_TRACKER_MACROS_SVH
`define LIST_FRESHNESS_REUSE_TRACKER_MACROS_SVH

// same-cycle check, off while reset is low
`define LFRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check in the cycle after the trigger, off while reset is low
`define LFRT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lfrt_pkg.sv =====
package lfrt_pkg;

  localparam int NODES_DEF  = 256;
  localparam int WINDOW_DEF = 64;

  // reuse thresholds in percent of the window
  localparam int PCT_SCALE = 100;
  localparam int DIS_PCT   = 10;
  localparam int EN_PCT    = 15;

  localparam int ID_W    = 9;
  localparam int OP_W    = 2;
  localparam int EPOCH_W = 32;

  localparam logic [OP_W-1:0] LIST_OP_NONE = 2'd0;
  localparam logic [OP_W-1:0] LIST_OP_GEN  = 2'd1;

  // input tdata layout
  localparam int OP_LSB     = 0;
  localparam int NODE_LSB   = 2;
  localparam int PAR_LSB    = 11;
  localparam int MUT_LSB    = 20;
  localparam int MNODE_LSB  = 21;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic accept;    // latch item, read node entry
    logic rd_par;    // capture node entry, read parent entry
    logic upd;       // node entry update, read mutation target
    logic mut;       // mutation write
    logic walk;      // clearing pass step
    logic out_load;  // load output register
  } lfrt_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic cnt_last;
    logic out_free;
  } lfrt_sts_t;

endpackage

// ===== rtl/core/lfrt_ram.sv =====
module lfrt_ram #(
  parameter int WIDTH = lfrt_pkg::EPOCH_W,
  parameter int DEPTH = lfrt_pkg::NODES_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lfrt_ctrl.sv =====
`include "list_freshness_reuse_tracker_macros.svh"

module lfrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  lfrt_pkg::lfrt_sts_t sts_i,
  output lfrt_pkg::lfrt_cmd_t cmd_o
);
  import lfrt_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RDP  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_MUT  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;
  localparam logic [2:0] S_CLR  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign accept        = (state_q == S_IDLE) && s_axis_tvalid;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.walk = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.in_clear ? S_CLR : S_RDP;
        end
      end
      S_RDP: begin
        cmd_o.rd_par = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_MUT;
      end
      S_MUT: begin
        cmd_o.mut = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_CLR: begin
        cmd_o.walk = 1'b1;
        if (sts_i.cnt_last) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  `LFRT_ASSERT_NEXT(a_walk_holds, (state_q == S_CLR) && !sts_i.cnt_last, state_q == S_CLR, "clear walk left early")
  `LFRT_ASSERT_NEXT(a_task_starts, accept && !sts_i.in_clear, state_q == S_RDP, "task did not start lookup")
  `LFRT_ASSERT_NEXT(a_upd_to_mut, state_q == S_UPD, state_q == S_MUT, "update not followed by mutation step")

endmodule

// ===== rtl/core/lfrt_datapath.sv =====
`include "list_freshness_reuse_tracker_macros.svh"

module lfrt_datapath #(
  parameter int NODES  = lfrt_pkg::NODES_DEF,
  parameter int WINDOW = lfrt_pkg::WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lfrt_pkg::lfrt_cmd_t                 cmd_i,
  output lfrt_pkg::lfrt_sts_t                 sts_o,
  input  logic [lfrt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [lfrt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i
);
  import lfrt_pkg::*;

  localparam int AW     = $clog2(NODES);
  localparam int CW     = $clog2(WINDOW + 1);
  localparam int LO_LIM = DIS_PCT * WINDOW;
  localparam int HI_LIM = EN_PCT * WINDOW;

  typedef struct packed {
    logic               valid;
    logic [EPOCH_W-1:0] drel;   // dirty epoch minus the global mutation epoch
    logic [EPOCH_W-1:0] clean;
    logic [EPOCH_W-1:0] pver;
    logic [EPOCH_W-1:0] lver;
    logic [WINDOW-1:0]  win;
    logic [CW-1:0]      fill;
    logic [CW-1:0]      hits;
    logic               dis;
  } entry_t;

  localparam int EW = $bits(entry_t);

  function automatic logic in_tab(logic [ID_W-1:0] v);
    return !v[ID_W-1] && (32'(v[ID_W-2:0]) < 32'(NODES));
  endfunction

  function automatic logic [AW-1:0] to_addr(logic [ID_W-1:0] v);
    logic [AW+ID_W-2:0] ext;
    ext = {{AW{1'b0}}, v[ID_W-2:0]};
    return ext[AW-1:0];
  endfunction

  // item fields
  logic              req_q;
  logic [OP_W-1:0]   op_q;
  logic [ID_W-1:0]   node_q, par_q, mnode_q;
  logic              mut_q;
  logic [ID_W-1:0]   in_node;

  entry_t            ent_q, nw_q;
  logic              skip_q, dis_q;
  logic              adapt_q;
  logic [EPOCH_W-1:0] gen_q, gen_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              cnt_last;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_data_q, out_data_d;
  logic              out_free;

  // memory ports
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  entry_t            rd_data, wr_data;
  logic [EW-1:0]     rd_bits;

  // update step
  entry_t            fresh, base, smp, w1, w2, node_after;
  logic [EPOCH_W-1:0] cur_dirty, pver;
  logic              node_in, elig, op_nz, hit, full, do_sample, skip, gen_go, node_we;
  logic              dis_res;
  logic [31:0]       hits_pct;

  // mutation step
  entry_t            m_raw, m_base, m_new;
  logic              mut_one, mut_all, mut_we;

  assign in_node = s_axis_tdata[NODE_LSB +: ID_W];

  always_comb begin
    rd_en = cmd_i.accept | cmd_i.rd_par | cmd_i.upd;
    if (cmd_i.accept) begin
      rd_addr = to_addr(in_node);
    end else if (cmd_i.rd_par) begin
      rd_addr = to_addr(par_q);
    end else begin
      rd_addr = to_addr(mnode_q);
    end
  end

  assign rd_data = entry_t'(rd_bits);

  // node entry decision and list generation
  always_comb begin
    fresh       = '0;
    fresh.valid = 1'b1;
    fresh.drel  = '0 - gen_q;

    node_in = in_tab(node_q);
    elig    = node_in && !par_q[ID_W-1];
    op_nz   = (op_q != LIST_OP_NONE);
    // in the update step the read port returns the parent entry
    pver    = (in_tab(par_q) && rd_data.valid) ? rd_data.lver : '0;

    base      = ent_q.valid ? ent_q : fresh;
    cur_dirty = base.drel + gen_q;
    hit       = ent_q.valid && (ent_q.clean == cur_dirty) && (ent_q.pver == pver);

    full     = (base.fill == CW'(WINDOW));
    smp      = base;
    hits_pct = '0;
    if (adapt_q) begin
      smp.fill = full ? base.fill : base.fill + CW'(1);
      smp.hits = base.hits - ((full && base.win[WINDOW-1]) ? CW'(1) : CW'(0))
                 + (hit ? CW'(1) : CW'(0));
      smp.win  = {base.win[WINDOW-2:0], hit};
      hits_pct = 32'(smp.hits) * 32'(PCT_SCALE);
      if (smp.fill == CW'(WINDOW)) begin
        if (!base.dis && (hits_pct < 32'(LO_LIM))) begin
          smp.dis = 1'b1;
        end else if (base.dis && (hits_pct >= 32'(HI_LIM))) begin
          smp.dis = 1'b0;
        end
      end
    end

    do_sample = op_nz && elig && (ent_q.valid || adapt_q);
    w1        = do_sample ? smp : base;
    skip      = op_nz && elig && ent_q.valid && hit && !w1.dis;
    gen_go    = !skip && (op_q == LIST_OP_GEN) && elig;

    w2 = w1;
    if (gen_go) begin
      w2.clean = cur_dirty;
      w2.pver  = pver;
      w2.lver  = w1.lver + EPOCH_W'(1);
    end

    node_we    = cmd_i.upd && (do_sample || gen_go);
    node_after = (do_sample || gen_go) ? w2 : ent_q;
    dis_res    = node_in && node_after.valid && node_after.dis;
  end

  // topology mutation
  always_comb begin
    // mutation target may be the node just written
    m_raw      = (mnode_q == node_q) ? nw_q : rd_data;
    m_base     = m_raw.valid ? m_raw : fresh;
    m_new      = m_base;
    m_new.drel = m_base.drel + EPOCH_W'(1);

    mut_one = !skip_q && mut_q && !mnode_q[ID_W-1] && in_tab(mnode_q);
    mut_all = !skip_q && mut_q && mnode_q[ID_W-1];
    mut_we  = cmd_i.mut && mut_one;
    gen_d   = (cmd_i.mut && mut_all) ? gen_q + EPOCH_W'(1) : gen_q;
  end

  always_comb begin
    wr_en = cmd_i.walk | node_we | mut_we;
    if (cmd_i.walk) begin
      wr_addr = cnt_q;
      wr_data = '0;
    end else if (node_we) begin
      wr_addr = to_addr(node_q);
      wr_data = w2;
    end else begin
      wr_addr = to_addr(mnode_q);
      wr_data = m_new;
    end
  end

  lfrt_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_bits)
  );

  assign cnt_last = (cnt_q == AW'(NODES - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.walk) begin
      cnt_d = cnt_last ? '0 : cnt_q + AW'(1);
    end
  end

  assign out_free    = !out_valid_q || m_axis_tready;
  assign out_valid_d = cmd_i.out_load || (out_valid_q && !m_axis_tready);
  assign out_data_d  = req_q ? 2'b00 : {dis_q, skip_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adapt_q     <= 1'b0;
      gen_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        adapt_q <= cfg_wdata_i;
      end
      gen_q       <= gen_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q   <= s_axis_tuser;
      op_q    <= s_axis_tdata[OP_LSB +: OP_W];
      node_q  <= in_node;
      par_q   <= s_axis_tdata[PAR_LSB +: ID_W];
      mut_q   <= s_axis_tdata[MUT_LSB];
      mnode_q <= s_axis_tdata[MNODE_LSB +: ID_W];
    end
    if (cmd_i.rd_par) begin
      ent_q <= rd_data;
    end
    if (cmd_i.upd) begin
      nw_q   <= node_after;
      skip_q <= skip;
      dis_q  <= dis_res;
    end
    if (cmd_i.out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign sts_o.in_clear = s_axis_tuser;
  assign sts_o.cnt_last = cnt_last;
  assign sts_o.out_free = out_free;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2){1'b0}}, out_data_q};

  `LFRT_ASSERT(a_load_free, !cmd_i.out_load || out_free, "output loaded while occupied")
  `LFRT_ASSERT(a_epoch_on_mut, (gen_q == $past(gen_q)) || $past(cmd_i.mut), "global epoch moved outside mutation")
  `LFRT_ASSERT_NEXT(a_clear_zero, cmd_i.out_load && req_q, out_data_q == 2'b00, "clear result not zero")

endmodule

// ===== rtl/core/list_freshness_reuse_tracker.sv =====
// a task transaction passes the parent read, update and mutation steps to the output register,
// waiting there while that register is full; no new task is taken before then, and the single
//   read port of the entry memory reads node entry, parent entry and mutation target in turn
// a clear transaction walks the entry memory and clears every entry
// reset: a clearing pass over every entry runs first with tready low; adaptive_enable resets to 0
module list_freshness_reuse_tracker #(
  parameter int NODES  = lfrt_pkg::NODES_DEF,
  parameter int WINDOW = lfrt_pkg::WINDOW_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // list_op[1:0], node_id[10:2], parent_id[19:11], may_mutate[20], mutation_node[29:21]
  input  logic [lfrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // skip_task[0], reuse_disabled[1]
  output logic [lfrt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i
);
  import lfrt_pkg::*;

  lfrt_cmd_t cmd;
  lfrt_sts_t sts;

  lfrt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  lfrt_datapath #(
    .NODES  (NODES),
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

endmodule
